// File: rtl/tfb_pkg.sv
// Shared types and constants for the telemetry frame builder.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package tfb_pkg;

    localparam int MAX_WORDS      = 63;
    localparam int WORD_W         = 32;
    localparam int COUNT_W        = 6;
    localparam int BYTE_W         = 8;
    localparam int BYTES_PER_WORD = 4;
    localparam int QUEUE_DEPTH    = 2;
    localparam int QPTR_W         = $clog2(QUEUE_DEPTH);

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [1:0] REG_HEADER = 2'd0;
    localparam logic [1:0] REG_ADDR   = 2'd1;
    localparam logic [1:0] REG_FUNC   = 2'd2;

    localparam logic [BYTE_W-1:0] HEADER_RST = 8'hAA;
    localparam logic [BYTE_W-1:0] ADDR_RST   = 8'hFF;
    localparam logic [BYTE_W-1:0] FUNC_RST   = 8'hF1;

    typedef struct packed {
        logic [BYTE_W-1:0] header_byte;
        logic [BYTE_W-1:0] target_address;
        logic [BYTE_W-1:0] function_code;
    } t_cfg;

    // One classified input item, as handed from front to back.
    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [BYTE_W-1:0] len_byte;
        logic              first;
        logic              has_word;
        logic              last;
    } t_cmd;

endpackage

// File: rtl/tfb_in_if.sv
// Input channel of the telemetry frame builder: valid/ready plus item fields.
// Depends on tfb_pkg for field widths.
`timescale 1ns / 1ps

interface tfb_in_if;
    import tfb_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [WORD_W-1:0]  data_word;
    logic        [COUNT_W-1:0] frame_words;

    modport source (output valid, output data_word, output frame_words, input ready);
    modport sink   (input valid, input data_word, input frame_words, output ready);
endinterface

// File: rtl/tfb_out_if.sv
// Output channel of the telemetry frame builder: one frame byte per item.
// Depends on tfb_pkg for field widths.
`timescale 1ns / 1ps

interface tfb_out_if;
    import tfb_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              frame_end;
    logic              run_end;

    modport source (output valid, output out_byte, output frame_end, output run_end,
                    input ready);
    modport sink   (input valid, input out_byte, input frame_end, input run_end,
                     output ready);
endinterface

// File: rtl/telemetry_frame_builder.sv
// Top level of the telemetry frame builder: APB registers, front end,
// command queue and byte sequencer. Depends on tfb_pkg and both channel interfaces.
`timescale 1ns / 1ps

// The block turns 32-bit words into framed bytes, one output byte per clock at
// most. The output rate is set by the byte sequencer in the back end: a word
// item sends its four word bytes, the first item of a frame first sends the
// header, address, function and length bytes, and the last item of a frame
// adds the two checksum bytes. A two-entry command queue sits between the
// input handshake and the sequencer, so input items are taken while earlier
// ones are still being sent and a registered output stage holds a byte while
// the sink stalls. Configuration registers are at byte addresses 0 (header),
// 4 (address) and 8 (function code) and should be written only while no frame
// is in flight.
module telemetry_frame_builder (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tfb_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [tfb_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [tfb_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready,
    tfb_in_if.sink                              i_in,
    tfb_out_if.source                           o_out
);
    import tfb_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;
    logic       push;
    logic       pop;
    logic       q_full;
    logic       q_empty;
    t_cmd       push_cmd;
    t_cmd       head_cmd;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header_byte    <= HEADER_RST;
            r_cfg.target_address <= ADDR_RST;
            r_cfg.function_code  <= FUNC_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_HEADER: r_cfg.header_byte    <= pwdata[BYTE_W-1:0];
                REG_ADDR:   r_cfg.target_address <= pwdata[BYTE_W-1:0];
                REG_FUNC:   r_cfg.function_code  <= pwdata[BYTE_W-1:0];
                default:    r_cfg                <= r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_HEADER: prdata = APB_DATA_W'(r_cfg.header_byte);
            REG_ADDR:   prdata = APB_DATA_W'(r_cfg.target_address);
            REG_FUNC:   prdata = APB_DATA_W'(r_cfg.function_code);
            default:    prdata = '0;
        endcase
    end

    tfb_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (push),
        .o_cmd    (push_cmd)
    );

    tfb_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head_cmd)
    );

    tfb_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_empty (q_empty),
        .i_head    (head_cmd),
        .o_pop     (pop),
        .o_out     (o_out)
    );

endmodule

// File: rtl/tfb_front.sv
// Front end: accepts input items, tracks the open frame, builds commands.
// Depends on tfb_pkg and tfb_in_if.
`timescale 1ns / 1ps

module tfb_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tfb_in_if.sink        i_in,
    input  logic          i_q_full,
    output logic          o_push,
    output tfb_pkg::t_cmd o_cmd
);
    import tfb_pkg::*;

    logic [COUNT_W-1:0] r_words_remaining;
    logic [COUNT_W-1:0] n_words_remaining;
    logic [COUNT_W-1:0] cnt;
    logic               first;

    assign i_in.ready = !i_q_full;
    assign o_push     = i_in.valid && !i_q_full;
    assign first      = (r_words_remaining == '0);

    always_comb begin
        cnt = i_in.frame_words;
        if (cnt > COUNT_W'(MAX_WORDS)) begin
            cnt = COUNT_W'(MAX_WORDS);
        end
        if (first) begin
            n_words_remaining = (cnt == '0) ? '0 : cnt - COUNT_W'(1);
        end else begin
            n_words_remaining = r_words_remaining - COUNT_W'(1);
        end
    end

    always_comb begin
        o_cmd.word     = i_in.data_word;
        o_cmd.len_byte = {cnt, 2'b00};   // four bytes per word
        o_cmd.first    = first;
        o_cmd.has_word = !(first && cnt == '0);
        o_cmd.last     = (n_words_remaining == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_words_remaining <= '0;
        end else if (o_push) begin
            r_words_remaining <= n_words_remaining;
        end
    end

endmodule

// File: rtl/tfb_cmd_queue.sv
// Short command queue between the front end and the byte sequencer.
// Depends on tfb_pkg for t_cmd and the queue depth.
`timescale 1ns / 1ps

module tfb_cmd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tfb_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output tfb_pkg::t_cmd o_head
);
    import tfb_pkg::*;

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;

    assign o_full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : r_rd_ptr + QPTR_W'(1);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + (QPTR_W+1)'(1);
                2'b01:   r_count <= r_count - (QPTR_W+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: rtl/tfb_back.sv
// Back end: walks each command byte by byte, keeps both checksums and
// holds the registered output stage. Depends on tfb_pkg and tfb_out_if.
`timescale 1ns / 1ps

module tfb_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  tfb_pkg::t_cfg i_cfg,
    input  logic          i_q_empty,
    input  tfb_pkg::t_cmd i_head,
    output logic          o_pop,
    tfb_out_if.source     o_out
);
    import tfb_pkg::*;

    typedef enum logic [3:0] {
        PH_HDR, PH_ADDR, PH_FUNC, PH_LEN,
        PH_W0, PH_W1, PH_W2, PH_W3,
        PH_SUM, PH_ADD
    } t_phase;

    t_phase            r_phase;
    logic              r_active;
    logic [BYTE_W-1:0] r_sum;
    logic [BYTE_W-1:0] r_add;
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_frame_end;
    logic              r_out_run_end;

    t_phase            cur_phase;
    t_phase            n_phase;
    logic              done;
    logic              emit;
    logic              summed;
    logic [BYTE_W-1:0] cur_byte;
    logic [BYTE_W-1:0] sum_base;
    logic [BYTE_W-1:0] add_base;
    logic [BYTE_W-1:0] n_sum;
    logic [BYTE_W-1:0] n_add;

    assign emit  = !i_q_empty && (!r_out_valid || o_out.ready);
    assign o_pop = emit && done;

    always_comb begin
        if (r_active) begin
            cur_phase = r_phase;
        end else begin
            cur_phase = i_head.first ? PH_HDR : PH_W0;
        end
    end

    always_comb begin
        cur_byte = '0;
        n_phase  = cur_phase;
        done     = 1'b0;
        summed   = 1'b1;
        unique case (cur_phase)
            PH_HDR: begin
                cur_byte = i_cfg.header_byte;
                n_phase  = PH_ADDR;
            end
            PH_ADDR: begin
                cur_byte = i_cfg.target_address;
                n_phase  = PH_FUNC;
            end
            PH_FUNC: begin
                cur_byte = i_cfg.function_code;
                n_phase  = PH_LEN;
            end
            PH_LEN: begin
                cur_byte = i_head.len_byte;
                n_phase  = i_head.has_word ? PH_W0 : PH_SUM;
            end
            PH_W0: begin
                cur_byte = i_head.word[7:0];
                n_phase  = PH_W1;
            end
            PH_W1: begin
                cur_byte = i_head.word[15:8];
                n_phase  = PH_W2;
            end
            PH_W2: begin
                cur_byte = i_head.word[23:16];
                n_phase  = PH_W3;
            end
            PH_W3: begin
                cur_byte = i_head.word[31:24];
                n_phase  = PH_SUM;
                done     = !i_head.last;
            end
            PH_SUM: begin
                cur_byte = r_sum;
                n_phase  = PH_ADD;
                summed   = 1'b0;
            end
            PH_ADD: begin
                cur_byte = r_add;
                done     = 1'b1;
                summed   = 1'b0;
            end
            default: begin
                cur_byte = '0;
                done     = 1'b1;
                summed   = 1'b0;
            end
        endcase
    end

    // Both sums restart at the header byte of every frame.
    always_comb begin
        sum_base = (cur_phase == PH_HDR) ? '0 : r_sum;
        add_base = (cur_phase == PH_HDR) ? '0 : r_add;
        n_sum    = sum_base + cur_byte;
        n_add    = add_base + n_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HDR;
            r_active    <= 1'b0;
            r_sum       <= '0;
            r_add       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_out_valid     <= 1'b1;
                r_out_byte      <= cur_byte;
                r_out_frame_end <= (cur_phase == PH_ADD);
                r_out_run_end   <= done;
                r_active        <= !done;
                r_phase         <= n_phase;
                if (summed) begin
                    r_sum <= n_sum;
                    r_add <= n_add;
                end
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.out_byte  = r_out_byte;
    assign o_out.frame_end = r_out_frame_end;
    assign o_out.run_end   = r_out_run_end;

endmodule

// File: tb/telemetry_frame_builder_test.sv
// Self-checking testbench for telemetry_frame_builder: directed rows, then random frames
// under several register settings, with every output byte checked against a frame predictor or a row's fixed bytes.
// Depends on tfb_pkg, tfb_in_if, tfb_out_if and the telemetry_frame_builder RTL.
`timescale 1ns / 1ps

module telemetry_frame_builder_test;
    import tfb_pkg::*;

    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_LIMIT   = 3000;
    localparam int DRAIN_CYCLES = 24;
    localparam int PHASE_ITEMS  = 45;
    localparam int NUM_DIRECTED = 11;
    localparam int NUM_PHASES   = 5;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef enum logic [1:0] {RX_FREE, RX_RANDOM, RX_SPARSE, RX_PERIODIC} t_rx_mode;

    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic              frame_end;
        logic              run_end;
    } t_frame_byte;

    typedef struct packed {
        logic [WORD_W-1:0]  word;
        logic [COUNT_W-1:0] words;
        logic [3:0]         n_fixed;
        logic [79:0]        fixed_bytes;  // first byte in the top octet
    } t_directed_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    tfb_in_if  in_ch();
    tfb_out_if out_ch();

    telemetry_frame_builder u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #4 i_clk = ~i_clk;

    // predictor state and register shadow
    logic [BYTE_W-1:0]  hdr_shadow;
    logic [BYTE_W-1:0]  addr_shadow;
    logic [BYTE_W-1:0]  func_shadow;
    logic [COUNT_W-1:0] words_left;
    logic [BYTE_W-1:0]  sum_acc;
    logic [BYTE_W-1:0]  add_acc;

    t_frame_byte   frame_bytes_due[$];
    t_frame_byte   due_byte;
    t_directed_row directed_rows[NUM_DIRECTED];

    int       mismatches  = 0;
    int       idle_cycles = 0;
    int       hold_req    = 0;
    int       tx_gap_max  = 0;
    int       burst_left  = 0;
    t_rx_mode rx_mode     = RX_FREE;

    task automatic report_mismatch(input string what, input logic [31:0] want_v,
                                   input logic [31:0] got_v);
        mismatches++;
        if (mismatches <= 40)
            $display("%0t mismatch on %s: expected %0h, got %0h", $time, what, want_v, got_v);
    endtask

    task automatic push_summed(input logic [BYTE_W-1:0] b);
        sum_acc = sum_acc + b;
        add_acc = add_acc + sum_acc;
        frame_bytes_due.push_back(t_frame_byte'{b, 1'b0, 1'b0});
    endtask

    task automatic push_word_bytes(input logic [WORD_W-1:0] w);
        for (int k = 0; k < BYTES_PER_WORD; k++)
            push_summed(w[8*k +: 8]);
    endtask

    // Expected bytes of one item; a 6-bit count never exceeds MAX_WORDS.
    task automatic predict_frame_bytes(input logic [WORD_W-1:0] w,
                                       input logic [COUNT_W-1:0] c);
        t_frame_byte last_b;
        if (words_left == 0) begin
            sum_acc = '0;
            add_acc = '0;
            push_summed(hdr_shadow);
            push_summed(addr_shadow);
            push_summed(func_shadow);
            push_summed({c, 2'b00});
            if (c != 0) begin
                push_word_bytes(w);
                words_left = c - 1'b1;
            end
        end else begin
            push_word_bytes(w);
            words_left = words_left - 1'b1;
        end
        // zero count and last word both close the frame
        if (words_left == 0) begin
            frame_bytes_due.push_back(t_frame_byte'{sum_acc, 1'b0, 1'b0});
            frame_bytes_due.push_back(t_frame_byte'{add_acc, 1'b1, 1'b0});
        end
        last_b = frame_bytes_due.pop_back();
        last_b.run_end = 1'b1;
        frame_bytes_due.push_back(last_b);
    endtask

    // Called just after a falling edge; returns at the falling edge after acceptance.
    task automatic offer_item(input logic [WORD_W-1:0] w, input logic [COUNT_W-1:0] c,
                              input int n_fixed, input logic [79:0] fixed_bytes);
        int keep;
        in_ch.valid       = 1'b1;
        in_ch.data_word   = w;
        in_ch.frame_words = c;
        do @(posedge i_clk); while (!in_ch.ready);
        keep = frame_bytes_due.size();
        predict_frame_bytes(w, c);
        if (n_fixed != 0) begin
            // fixed rows are whole frames: the state still advances, bytes come from the row
            while (frame_bytes_due.size() > keep)
                void'(frame_bytes_due.pop_back());
            for (int k = 0; k < n_fixed; k++)
                frame_bytes_due.push_back(t_frame_byte'{fixed_bytes[79-8*k -: 8],
                                                        k == n_fixed - 1, k == n_fixed - 1});
        end
        @(negedge i_clk);
    endtask

    task automatic wait_all_bytes;
        in_ch.valid = 1'b0;
        while (frame_bytes_due.size() != 0)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [BYTE_W-1:0] v);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = APB_ADDR_W'({idx, 2'b00});
        pwdata  = $urandom();
        pwdata[BYTE_W-1:0] = v;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_HEADER: hdr_shadow = v;
            REG_ADDR:   addr_shadow = v;
            REG_FUNC:   func_shadow = v;
            default: ;
        endcase
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic apb_check_read(input logic [1:0] idx, input logic [BYTE_W-1:0] want);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = APB_ADDR_W'({idx, 2'b00});
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== APB_DATA_W'(want))
            report_mismatch("register readback", APB_DATA_W'(want), prdata);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // Random frames until n_items are sent and the last frame is closed.
    task automatic run_random_phase(input int n_items, input logic want_long, input int hold_at);
        int                 sent;
        int                 r;
        logic [COUNT_W-1:0] c;
        sent = 0;
        while (sent < n_items || words_left != 0) begin
            if (words_left != 0) begin
                c = COUNT_W'($urandom());  // ignored mid-frame
            end else if (want_long) begin
                c = COUNT_W'(MAX_WORDS);
                want_long = 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 10)
                    c = '0;
                else if (r < 65)
                    c = COUNT_W'($urandom_range(1, 4));
                else if (r < 88)
                    c = COUNT_W'($urandom_range(5, 15));
                else if (r < 96)
                    c = COUNT_W'($urandom_range(16, MAX_WORDS - 1));
                else
                    c = COUNT_W'(MAX_WORDS);
            end
            if (burst_left == 0) begin
                if (tx_gap_max > 0) begin
                    in_ch.valid       = 1'b0;
                    in_ch.data_word   = $urandom();
                    in_ch.frame_words = COUNT_W'($urandom());
                    repeat ($urandom_range(1, tx_gap_max)) @(negedge i_clk);
                end
                burst_left = $urandom_range(1, 12);
            end
            burst_left--;
            offer_item($urandom(), c, 0, '0);
            sent++;
            if (sent == hold_at)
                hold_req = HOLD_CYCLES;
        end
        wait_all_bytes();
    endtask

    // receiver: stall pattern per phase, plus one long hold-off on request
    initial begin
        int tick;
        tick = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req != 0) begin
                out_ch.ready = 1'b0;
                repeat (hold_req - 1) @(negedge i_clk);
                hold_req = 0;
            end else begin
                case (rx_mode)
                    RX_FREE:   out_ch.ready = 1'b1;
                    RX_RANDOM: out_ch.ready = 1'($urandom_range(0, 1));
                    RX_SPARSE: out_ch.ready = ($urandom_range(0, 3) == 0);
                    default: begin
                        out_ch.ready = (tick % 9) < 5;
                        tick++;
                    end
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (frame_bytes_due.size() == 0) begin
                report_mismatch("byte with none due", '0, 32'(out_ch.out_byte));
            end else begin
                due_byte = frame_bytes_due.pop_front();
                if (out_ch.out_byte !== due_byte.value)
                    report_mismatch("out_byte", 32'(due_byte.value), 32'(out_ch.out_byte));
                if (out_ch.frame_end !== due_byte.frame_end)
                    report_mismatch("frame_end", 32'(due_byte.frame_end),
                                    32'(out_ch.frame_end));
                if (out_ch.run_end !== due_byte.run_end)
                    report_mismatch("run_end", 32'(due_byte.run_end), 32'(out_ch.run_end));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [BYTE_W-1:0] h;
        logic [BYTE_W-1:0] a;
        logic [BYTE_W-1:0] f;
        i_rst_n           = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        in_ch.valid       = 1'b0;
        in_ch.data_word   = '0;
        in_ch.frame_words = '0;
        hdr_shadow        = HEADER_RST;
        addr_shadow       = ADDR_RST;
        func_shadow       = FUNC_RST;
        words_left        = '0;
        sum_acc           = '0;
        add_acc           = '0;

        // zero-count frame and a single zero word, both under reset registers
        directed_rows[0]  = '{32'h1234_5678, 6'd0,  4'd6,  80'hAA_FF_F1_00_9A_87_00_00_00_00};
        directed_rows[1]  = '{32'h0000_0000, 6'd1,  4'd10, 80'hAA_FF_F1_04_00_00_00_00_9E_03};
        directed_rows[2]  = '{32'hFFFF_FFFF, 6'd1,  4'd0,  80'h0};
        directed_rows[3]  = '{32'h8000_0000, 6'd1,  4'd0,  80'h0};
        directed_rows[4]  = '{32'h7FFF_FFFF, 6'd1,  4'd0,  80'h0};
        directed_rows[5]  = '{32'hA5A5_A5A5, 6'd2,  4'd0,  80'h0};
        directed_rows[6]  = '{32'h5A5A_5A5A, 6'd63, 4'd0,  80'h0};  // count ignored mid-frame
        directed_rows[7]  = '{32'h0123_4567, 6'd3,  4'd0,  80'h0};
        directed_rows[8]  = '{32'h89AB_CDEF, 6'd0,  4'd0,  80'h0};
        directed_rows[9]  = '{32'hFEDC_BA98, 6'd42, 4'd0,  80'h0};
        directed_rows[10] = '{32'h0000_0001, 6'd0,  4'd0,  80'h0};

        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < NUM_DIRECTED; i++)
            offer_item(directed_rows[i].word, directed_rows[i].words,
                       directed_rows[i].n_fixed, directed_rows[i].fixed_bytes);
        wait_all_bytes();

        rx_mode    = RX_RANDOM;
        tx_gap_max = 3;
        run_random_phase(PHASE_ITEMS, 1'b0, 0);

        for (int p = 1; p <= NUM_PHASES; p++) begin
            case (p)
                1: begin
                    h = 8'h00; a = 8'h00; f = 8'hF1;
                    rx_mode = RX_RANDOM;   tx_gap_max = 3;
                end
                2: begin
                    h = 8'hFF; a = 8'hFF; f = 8'hFA;
                    rx_mode = RX_SPARSE;   tx_gap_max = 0;
                end
                3: begin
                    h = 8'h5C; a = 8'h01; f = 8'h00;  // function code out of its range
                    rx_mode = RX_PERIODIC; tx_gap_max = 5;
                end
                4: begin
                    h = 8'hFF; a = 8'h00; f = 8'hFF;
                    rx_mode = RX_FREE;     tx_gap_max = 4;
                end
                default: begin
                    h = BYTE_W'($urandom());
                    a = BYTE_W'($urandom());
                    f = BYTE_W'($urandom_range(8'hF1, 8'hFA));
                    rx_mode = RX_RANDOM;   tx_gap_max = 2;
                end
            endcase
            apb_write(REG_HEADER, h);
            apb_write(REG_ADDR, a);
            apb_write(REG_FUNC, f);
            if (p == 3)
                apb_write(REG_UNUSED, BYTE_W'($urandom()));  // no register there
            apb_check_read(REG_HEADER, hdr_shadow);
            apb_check_read(REG_ADDR, addr_shadow);
            apb_check_read(REG_FUNC, func_shadow);
            run_random_phase(PHASE_ITEMS, p == 2, (p == 3) ? 5 : 0);
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && frame_bytes_due.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: filelist.f
rtl/tfb_pkg.sv
rtl/tfb_in_if.sv
rtl/tfb_out_if.sv
rtl/tfb_front.sv
rtl/tfb_cmd_queue.sv
rtl/tfb_back.sv
rtl/telemetry_frame_builder.sv
tb/telemetry_frame_builder_test.sv
